### hw/rtl/b64d_pkg.sv
// b64d_pkg: shared types, character codes and the alphabet lookup for the
// base64 decoder. No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package b64d_pkg;

  // Character codes outside the letter and digit ranges
  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7A;
  localparam logic [7:0] Digit0    = 8'h30;
  localparam logic [7:0] Digit9    = 8'h39;

  // Sextet offsets of the lower-case and digit ranges
  localparam logic [7:0] LowerBase = 8'd26;
  localparam logic [7:0] DigitBase = 8'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  // Classified character, as queued between front and back
  typedef struct packed {
    logic       last;    // final character of the message
    logic       alpha;   // character is in the alphabet
    logic       pad;     // character is '='
    logic [5:0] sextet;  // alphabet value, zero when not alpha
  } class_t;

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    logic       bad_input;
  } result_t;

  // Map one character to its class and sextet
  function automatic class_t classify(logic [7:0] c, logic last);
    class_t r;
    logic [7:0] v;
    r.last   = last;
    r.alpha  = 1'b1;
    r.pad    = (c == PadChar);
    v        = 8'd0;
    if (c >= UpperA && c <= UpperZ) begin
      v = c - UpperA;
    end else if (c >= LowerA && c <= LowerZ) begin
      v = c - LowerA + LowerBase;
    end else if (c >= Digit0 && c <= Digit9) begin
      v = c - Digit0 + DigitBase;
    end else if (c == PlusChar) begin
      v = {2'b00, PlusCode};
    end else if (c == SlashChar) begin
      v = {2'b00, SlashCode};
    end else begin
      r.alpha = 1'b0;
    end
    r.sextet = v[5:0];
    return r;
  endfunction

endpackage

### hw/rtl/b64d_front.sv
// b64d_front: accepts characters, classifies them against the alphabet and
// holds them in a two-entry queue for the back end. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      code_char,
  input  logic            end_of_text,
  output logic            item_valid,
  output b64d_pkg::class_t item,
  input  logic            item_take
);
  import b64d_pkg::*;

  class_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  // Store the classified character on each input transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= classify(code_char, end_of_text);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hw/rtl/b64d_back.sv
// b64d_back: group tracking, byte assembly and padding/error handling, with a
// two-entry result queue towards the output. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  b64d_pkg::class_t item,
  output logic             item_take,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       data_byte,
  output logic             byte_valid,
  output logic             message_done,
  output logic             bad_input
);
  import b64d_pkg::*;

  // Decoder state
  logic [1:0] group_position;
  logic [5:0] held_sextet;
  logic       stop_after_group;
  logic       stopped;
  logic       error_seen;

  logic [1:0] group_position_next;
  logic [5:0] held_sextet_next;
  logic       stop_after_group_next;
  logic       stopped_next;
  logic       error_seen_next;

  logic       have_byte;
  logic [7:0] byte_val;
  logic       emit;
  result_t    res;

  // Result queue
  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign item_take = item_valid && (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign do_pop    = pop && !empty;

  // Work out the next state and the byte for the item at the queue head
  always_comb begin
    group_position_next   = group_position;
    held_sextet_next      = held_sextet;
    stop_after_group_next = stop_after_group;
    stopped_next          = stopped;
    error_seen_next       = error_seen;
    have_byte             = 1'b0;
    byte_val              = 8'd0;
    if (!stopped) begin
      if (!item.alpha) begin
        if (group_position[1] && item.pad) begin
          if (group_position == 2'd2) begin
            stop_after_group_next = 1'b1;
            group_position_next   = 2'd3;
          end else begin
            stopped_next        = 1'b1;
            group_position_next = 2'd0;
          end
        end else begin
          error_seen_next = 1'b1;
          stopped_next    = 1'b1;
        end
      end else if (stop_after_group) begin
        // fourth place after padding: checked only
        stopped_next        = 1'b1;
        group_position_next = 2'd0;
      end else begin
        unique case (group_position)
          2'd0: begin
            have_byte = item.last;
            byte_val  = {2'b00, item.sextet};
          end
          2'd1: begin
            have_byte = 1'b1;
            byte_val  = {held_sextet, item.sextet[5:4]};
          end
          2'd2: begin
            have_byte = 1'b1;
            byte_val  = {held_sextet[3:0], item.sextet[5:2]};
          end
          default: begin
            have_byte = 1'b1;
            byte_val  = {held_sextet[1:0], item.sextet};
          end
        endcase
        held_sextet_next    = item.sextet;
        group_position_next = group_position + 2'd1;
      end
    end
    emit             = have_byte || item.last;
    res.data_byte    = byte_val;
    res.byte_valid   = have_byte;
    res.message_done = item.last;
    res.bad_input    = item.last && error_seen_next;
  end

  // Update decoder state per taken item; drop everything at end of message
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position   <= 2'd0;
      held_sextet      <= 6'd0;
      stop_after_group <= 1'b0;
      stopped          <= 1'b0;
      error_seen       <= 1'b0;
    end else if (item_take) begin
      if (item.last) begin
        group_position   <= 2'd0;
        held_sextet      <= 6'd0;
        stop_after_group <= 1'b0;
        stopped          <= 1'b0;
        error_seen       <= 1'b0;
      end else begin
        group_position   <= group_position_next;
        held_sextet      <= held_sextet_next;
        stop_after_group <= stop_after_group_next;
        stopped          <= stopped_next;
        error_seen       <= error_seen_next;
      end
    end
  end

  // Hold results until transferred
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (item_take && emit) wr_ptr <= ~wr_ptr;
      if (do_pop)            rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, item_take && emit} - {1'b0, do_pop};
    end
  end

  assign data_byte    = mem[rd_ptr].data_byte;
  assign byte_valid   = mem[rd_ptr].byte_valid;
  assign message_done = mem[rd_ptr].message_done;
  assign bad_input    = mem[rd_ptr].bad_input;

endmodule

### hw/rtl/base64_decoder_unit.sv
// base64_decoder_unit: streaming base64 decoder, top level.
// Instantiates b64d_front and b64d_back; types from b64d_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | push / full         | code_char[7:0], end_of_text
//  result   | pop / empty         | data_byte[7:0], byte_valid, message_done,
//           |                     | bad_input
//
// One character per cycle sustained while full is low. The front queue
// registers each character for the back end, whose result is registered in
// the result queue. Both queues hold two entries, so each side stalls on its
// own; the back end takes a character whenever its result queue has room.
// rst (synchronous) clears all queues and returns the decoder to group start.
`timescale 1ns / 1ps

module base64_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] code_char,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       message_done,
  output logic       bad_input
);
  import b64d_pkg::*;

  logic   item_valid;
  logic   item_take;
  class_t item;

  // Classify and queue incoming characters
  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .code_char   (code_char),
    .end_of_text (end_of_text),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  // Decode and queue results
  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .empty        (empty),
    .pop          (pop),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .message_done (message_done),
    .bad_input    (bad_input)
  );

endmodule

### tb/tb.sv
// tb: self-checking testbench for base64_decoder_unit (streaming base64 decode).
// Depends on b64d_pkg for the result type and character codes, and on the RTL
// of base64_decoder_unit; a scoreboard class predicts and checks every byte.
`timescale 1ns / 1ps

module tb;
  import b64d_pkg::*;

  // Tracks the decoder state for each accepted character and holds the
  // results still owed by the block, oldest first
  class byte_scoreboard;
    logic [1:0] group_pos = 2'd0;
    logic [5:0] held = 6'd0;
    logic       stop_after = 1'b0;
    logic       halted = 1'b0;
    logic       err = 1'b0;
    result_t    awaited_bytes[$];
    int         mismatches = 0;
    int         checked = 0;
    int         flagged = 0;

    // Alphabet value in [5:0], bit 6 set for anything outside the alphabet
    function automatic logic [6:0] sextet_value(logic [7:0] c);
      if (c >= UpperA && c <= UpperZ) return {1'b0, 6'(c - UpperA)};
      if (c >= LowerA && c <= LowerZ) return {1'b0, 6'(c - LowerA + 8'd26)};
      if (c >= Digit0 && c <= Digit9) return {1'b0, 6'(c - Digit0 + 8'd52)};
      if (c == PlusChar) return {1'b0, PlusCode};
      if (c == SlashChar) return {1'b0, SlashCode};
      return 7'h40;
    endfunction

    function void clear_state();
      group_pos = 2'd0;
      held = 6'd0;
      stop_after = 1'b0;
      halted = 1'b0;
      err = 1'b0;
    endfunction

    // Advance the decoder by one accepted character and queue its result
    function void note_char(logic [7:0] c, logic last);
      logic [6:0] v;
      logic       have;
      logic [7:0] b;
      result_t    r;
      have = 1'b0;
      b = 8'd0;
      if (!halted) begin
        v = sextet_value(c);
        if (v[6]) begin
          if (group_pos >= 2'd2 && c == PadChar) begin
            if (group_pos == 2'd2) begin
              stop_after = 1'b1;
              group_pos = 2'd3;
            end else begin
              halted = 1'b1;
              group_pos = 2'd0;
            end
          end else begin
            err = 1'b1;
            halted = 1'b1;
          end
        end else if (stop_after) begin
          // fourth place after padding: checked, then decoding ends
          halted = 1'b1;
          group_pos = 2'd0;
        end else begin
          case (group_pos)
            2'd0: begin
              if (last) begin
                b = {2'b00, v[5:0]};
                have = 1'b1;
              end
            end
            2'd1: begin
              b = {held, v[5:4]};
              have = 1'b1;
            end
            2'd2: begin
              b = {held[3:0], v[5:2]};
              have = 1'b1;
            end
            default: begin
              b = {held[1:0], v[5:0]};
              have = 1'b1;
            end
          endcase
          held = v[5:0];
          group_pos = group_pos + 2'd1;
        end
      end
      if (have || last) begin
        r.data_byte = b;
        r.byte_valid = have;
        r.message_done = last;
        r.bad_input = last & err;
        awaited_bytes.push_back(r);
      end
      if (last) clear_state();
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(result_t got);
      result_t exp;
      checked++;
      if (got.bad_input) flagged++;
      if (awaited_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: data %h valid %b done %b bad %b", $realtime,
                   got.data_byte, got.byte_valid, got.message_done, got.bad_input);
        return;
      end
      exp = awaited_bytes.pop_front();
      if (got.data_byte !== exp.data_byte || got.byte_valid !== exp.byte_valid ||
          got.message_done !== exp.message_done || got.bad_input !== exp.bad_input) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: expected data %h valid %b done %b bad %b, %s %h %b %b %b",
                   $realtime, exp.data_byte, exp.byte_valid, exp.message_done, exp.bad_input,
                   "got", got.data_byte, got.byte_valid, got.message_done, got.bad_input);
      end
    endfunction

    function int pending();
      return awaited_bytes.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] code_char;
  logic       end_of_text;
  logic       empty;
  logic       pop;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_done;
  logic       bad_input;

  byte_scoreboard sb;
  result_t        seen;
  int             snd_idle = 27;
  int             rcv_idle = 81;
  int             hold_left = 0;
  logic           hold_req = 1'b0;
  logic           hold_taken = 1'b0;
  int             msg_count = 0;
  int             char_count = 0;
  int             input_stalls = 0;

  base64_decoder_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .code_char(code_char),
    .end_of_text(end_of_text),
    .empty(empty),
    .pop(pop),
    .data_byte(data_byte),
    .byte_valid(byte_valid),
    .message_done(message_done),
    .bad_input(bad_input)
  );

  // Free-running clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels at every edge and feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_char(code_char, end_of_text);
        char_count++;
      end
      if (push && full) input_stalls++;
      if (pop && !empty) begin
        seen.data_byte = data_byte;
        seen.byte_valid = byte_valid;
        seen.message_done = message_done;
        seen.bad_input = bad_input;
        sb.check_result(seen);
      end
    end
  end

  // Receiver: random pop, or hold off for a counted stretch once requested
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      pop <= 1'b0;
      hold_taken = 1'b1;
      hold_left = 59;
    end else begin
      pop <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Offer one character, with a random gap first, and wait for its transfer
  task automatic send_char(input logic [7:0] c, input logic last);
    while (snd_idle != 0 && $urandom_range(0, 99) < snd_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    code_char <= c;
    end_of_text <= last;
    do @(posedge clk); while (full);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    msg_count++;
  endtask

  function automatic logic [7:0] to_char(logic [5:0] s);
    if (s < 6'd26) return UpperA + 8'(s);
    if (s < 6'd52) return LowerA + 8'(s - 6'd26);
    if (s < 6'd62) return Digit0 + 8'(s - 6'd52);
    if (s == PlusCode) return PlusChar;
    return SlashChar;
  endfunction

  // Build one message: mostly a proper encoding of random bytes, some noise,
  // some with a corrupted character or junk appended at the end
  task automatic send_random_message(output int counted);
    logic [7:0]  text[$];
    logic [23:0] w;
    int          n;
    int          kind;
    int          i;
    int          rem;
    logic        padded;
    n = $urandom_range(0, 12);
    kind = $urandom_range(0, 99);
    padded = 1'b0;
    if (kind < 8) begin
      for (i = 0; i < $urandom_range(1, 6); i++) text.push_back(8'($urandom()));
    end else begin
      for (i = 0; i < n; i += 3) begin
        rem = n - i;
        w = 24'($urandom());
        text.push_back(to_char(w[23:18]));
        text.push_back(to_char(w[17:12]));
        if (rem >= 2) text.push_back(to_char(w[11:6]));
        if (rem >= 3) text.push_back(to_char(w[5:0]));
        if (rem < 3 && $urandom_range(0, 1) == 1) begin
          if (rem == 1) text.push_back(PadChar);
          text.push_back(PadChar);
          padded = 1'b1;
        end
      end
      // lone trailing character after whole groups
      if (n % 3 == 0 && (n == 0 || $urandom_range(0, 3) == 0))
        text.push_back(to_char(6'($urandom())));
      if (kind >= 75 && kind < 88) begin
        i = $urandom_range(0, text.size() - 1);
        text[i] = ($urandom_range(0, 1) == 1) ? PadChar : 8'($urandom());
      end
    end
    counted = text.size();
    if (kind >= 88 || (padded && $urandom_range(0, 3) == 0)) begin
      for (i = 0; i < $urandom_range(1, 3); i++) text.push_back(8'($urandom()));
      if (!padded && kind >= 8) counted = text.size();
    end
    for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    msg_count++;
  endtask

  task automatic random_phase(input int target);
    int sent;
    int got;
    sent = 0;
    while (sent < target) begin
      send_random_message(got);
      sent += got;
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    code_char = 8'd0;
    end_of_text = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: full group then lone char, padding in each allowed place,
    // junk after padding, padding too early, invalid codes at both extremes
    send_text("TWFu/");
    send_text("+/9=x");
    send_text("AA==");
    send_text("zz=AB");
    send_text("=");
    send_text("Q=");
    send_char(SlashChar, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(Digit0, 1'b1);
    send_char(8'h00, 1'b1);
    msg_count += 2;

    // Sender busy, receiver sparse
    random_phase(165);

    // Pause until everything owed has arrived
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);

    // Sender sparse, receiver busy
    snd_idle = 81;
    rcv_idle = 27;
    random_phase(165);

    // Full rate, with one long receiver hold-off to back up the input
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 1'b1;
    random_phase(165);

    // Drain, then let the pipeline settle
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters in %0d messages; checked %0d results, %0d flagged bad.",
             char_count, msg_count, sb.checked, sb.flagged);
    $display("Input stalled on %0d cycles under receiver back-pressure.", input_stalls);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("base64_decoder_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
      $display("base64_decoder_unit verification failed");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("base64_decoder_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_decoder_unit.sv
tb/tb.sv
